// ===== rtl/text_stream_line_number_escape_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the text stream filter
// Same-cycle and next-cycle implication checks under synchronous reset.
// ----------------------------------------------------------------------------
`ifndef TEXT_STREAM_LINE_NUMBER_ESCAPE_ASSERT_SVH
`define TEXT_STREAM_LINE_NUMBER_ESCAPE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define TSLE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tsle check failed");

// Consequent must hold in the cycle after the antecedent
`define TSLE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tsle check failed");

`endif

// ===== rtl/tsle_pkg.sv =====
// ----------------------------------------------------------------------------
// tsle_pkg
// Types, sizes and character codes shared by the text stream filter.
// ----------------------------------------------------------------------------
package tsle_pkg;

    // Line number width in decimal digits and derived sizes
    localparam int NUM_DIGITS = 6;
    localparam int CNT_W      = 4 * NUM_DIGITS;
    localparam int PREFIX_LEN = NUM_DIGITS + 1;
    localparam int BODY_MAX   = 4;
    localparam int JOB_MAX    = PREFIX_LEN + BODY_MAX;
    localparam int LEN_W      = $clog2(JOB_MAX + 1);
    localparam int POS_W      = $clog2(JOB_MAX);
    localparam int BODY_W     = $clog2(BODY_MAX + 1);
    localparam int CFG_IDX_W  = 3;

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUMBER_ALL      = 3'd0,
        REG_NUMBER_NONBLANK = 3'd1,
        REG_SQUEEZE_BLANK   = 3'd2,
        REG_SHOW_NONPRINT   = 3'd3,
        REG_SHOW_TABS       = 3'd4,
        REG_SHOW_ENDS       = 3'd5
    } t_cfg_reg;

    // Character codes
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_I      = 8'h49;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [6:0] CH_DEL    = 7'h7F;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       first_of_file;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } t_out_item;

    typedef struct packed {
        logic number_all;
        logic number_nonblank;
        logic squeeze_blank;
        logic show_nonprint;
        logic show_tabs;
        logic show_ends;
    } t_cfg;

    // All bytes one input item produces, in output order
    typedef struct packed {
        logic [JOB_MAX-1:0][7:0] bytes;
        logic [LEN_W-1:0]        len;
    } t_job;

endpackage

// ===== rtl/tsle_core.sv =====
// ----------------------------------------------------------------------------
// tsle_core
// Line state and per-item expansion into a list of output bytes.
// ----------------------------------------------------------------------------
module tsle_core
    import tsle_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_accept,
    input  t_in_item i_item,
    output logic     o_job_valid,
    output t_job     o_job
);

    logic [CNT_W-1:0] r_cnt;
    logic             r_start;
    logic [1:0]       r_run;

    logic [CNT_W-1:0] base_cnt;
    logic             base_start;
    logic [1:0]       base_run;
    logic [7:0]       c;
    logic             is_lf;
    logic             squeezed;
    logic             do_num;
    logic             all_nine;
    logic             carry;
    logic             seen;
    logic [3:0]       dig;
    logic [CNT_W-1:0] inc_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic [1:0]       n_run;
    logic [PREFIX_LEN-1:0][7:0] prefix;
    logic [BODY_MAX-1:0][7:0]   body;
    logic [BODY_W-1:0]          nb;
    logic [1:0][7:0]            esc;
    logic [BODY_W-1:0]          esc_n;

    // Apply file start, then decide squeeze and numbering
    always_comb begin
        c          = i_item.in_byte;
        base_cnt   = i_item.first_of_file ? '0 : r_cnt;
        base_start = i_item.first_of_file ? 1'b1 : r_start;
        base_run   = i_item.first_of_file ? 2'd1 : r_run;
        is_lf      = (c == CH_LF);
        squeezed   = i_cfg.squeeze_blank && is_lf && base_run[1];
        do_num     = base_start && (i_cfg.number_nonblank ? !is_lf : i_cfg.number_all);
    end

    // Saturating BCD increment, digit by digit from the bottom
    always_comb begin
        all_nine = 1'b1;
        for (int d = 0; d < NUM_DIGITS; d++) begin
            if (base_cnt[4*d +: 4] != 4'd9) all_nine = 1'b0;
        end
        inc_cnt = base_cnt;
        carry   = !all_nine;
        for (int d = 0; d < NUM_DIGITS; d++) begin
            if (carry) begin
                if (base_cnt[4*d +: 4] == 4'd9) begin
                    inc_cnt[4*d +: 4] = 4'd0;
                end else begin
                    inc_cnt[4*d +: 4] = base_cnt[4*d +: 4] + 4'd1;
                    carry = 1'b0;
                end
            end
        end
    end

    // Right-justified number with blank padding, then a tab
    always_comb begin
        seen = 1'b0;
        dig  = '0;
        for (int d = NUM_DIGITS - 1; d >= 0; d--) begin
            dig = inc_cnt[4*d +: 4];
            if (dig != 4'd0 || d == 0) seen = 1'b1;
            prefix[NUM_DIGITS-1-d] = seen ? (CH_ZERO | {4'h0, dig}) : CH_SPACE;
        end
        prefix[NUM_DIGITS] = CH_TAB;
    end

    // Caret form of the low seven bits
    always_comb begin
        if (c[6:5] == 2'b00) begin
            esc[0] = CH_CARET;
            esc[1] = {3'b010, c[4:0]};
            esc_n  = BODY_W'(2);
        end else if (c[6:0] == CH_DEL) begin
            esc[0] = CH_CARET;
            esc[1] = CH_QMARK;
            esc_n  = BODY_W'(2);
        end else begin
            esc[0] = {1'b0, c[6:0]};
            esc[1] = '0;
            esc_n  = BODY_W'(1);
        end
    end

    // Bytes of the character itself
    always_comb begin
        body = '0;
        nb   = BODY_W'(1);
        if (is_lf) begin
            if (i_cfg.show_ends) begin
                body[0] = CH_DOLLAR;
                body[1] = CH_LF;
                nb      = BODY_W'(2);
            end else begin
                body[0] = CH_LF;
            end
        end else if (c == CH_TAB) begin
            if (i_cfg.show_tabs) begin
                body[0] = CH_CARET;
                body[1] = CH_I;
                nb      = BODY_W'(2);
            end else begin
                body[0] = CH_TAB;
            end
        end else if (i_cfg.show_nonprint) begin
            if (c[7]) begin
                body[0] = CH_M;
                body[1] = CH_DASH;
                body[2] = esc[0];
                body[3] = esc[1];
                nb      = BODY_W'(2) + esc_n;
            end else begin
                body[0] = esc[0];
                body[1] = esc[1];
                nb      = esc_n;
            end
        end else begin
            body[0] = c;
        end
    end

    // Pack prefix and body into one list
    always_comb begin
        o_job.bytes = '0;
        if (do_num) begin
            for (int k = 0; k < PREFIX_LEN; k++) o_job.bytes[k] = prefix[k];
            for (int k = 0; k < BODY_MAX; k++) o_job.bytes[PREFIX_LEN+k] = body[k];
            o_job.len = LEN_W'(PREFIX_LEN) + LEN_W'(nb);
        end else begin
            for (int k = 0; k < BODY_MAX; k++) o_job.bytes[k] = body[k];
            o_job.len = LEN_W'(nb);
        end
        o_job_valid = i_accept && !squeezed;
    end

    // Next line state
    always_comb begin
        n_cnt = do_num ? inc_cnt : base_cnt;
        if (!is_lf)           n_run = 2'd0;
        else if (base_run[1]) n_run = 2'd2;
        else                  n_run = base_run + 2'd1;
    end

    // Update state on every item that is not squeezed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_start <= 1'b1;
            r_run   <= 2'd1;
        end else if (i_accept && !squeezed) begin
            r_cnt   <= n_cnt;
            r_start <= is_lf;
            r_run   <= n_run;
        end
    end

endmodule

// ===== rtl/tsle_emit.sv =====
// ----------------------------------------------------------------------------
// tsle_emit
// Holds one expanded item and sends its bytes through the output register.
// ----------------------------------------------------------------------------
`include "text_stream_line_number_escape_assert.svh"

module tsle_emit
    import tsle_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_job_valid,
    input  t_job      i_job,
    output logic      o_job_ready,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out
);

    logic             r_job_valid;
    t_job             r_job;
    logic [POS_W-1:0] r_pos;
    logic             r_out_valid;
    t_out_item        r_out;

    logic out_free;
    logic move;
    logic last;

    // Move one byte whenever the output register can take it
    always_comb begin
        out_free    = !r_out_valid || !i_out_stall;
        move        = r_job_valid && out_free;
        last        = (LEN_W'(r_pos) + LEN_W'(1)) == r_job.len;
        o_job_ready = !r_job_valid || (move && last);
        o_out_valid = r_out_valid;
        o_out       = r_out;
    end

    // Control: item buffer occupancy, byte position, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
            if (i_job_valid) begin
                r_job_valid <= 1'b1;
                r_pos       <= '0;
            end else if (move) begin
                if (last) begin
                    r_job_valid <= 1'b0;
                    r_pos       <= '0;
                end else begin
                    r_pos <= r_pos + POS_W'(1);
                end
            end
        end
    end

    // Payload: load item, drive output byte
    always_ff @(posedge i_clk) begin
        if (i_job_valid) begin
            r_job <= i_job;
        end
        if (move) begin
            r_out.out_byte    <= r_job.bytes[r_pos];
            r_out.last_of_run <= last;
        end
    end

    `TSLE_ASSERT_IMP(a_load_when_ready, i_clk, i_rst_n, i_job_valid, o_job_ready)
    `TSLE_ASSERT_IMP(a_pos_in_range, i_clk, i_rst_n, r_job_valid,
                     LEN_W'(r_pos) < r_job.len)
    `TSLE_ASSERT_NXT(a_pos_advances, i_clk, i_rst_n, move && !last && !i_job_valid,
                     r_job_valid && (r_pos == $past(r_pos) + POS_W'(1)))
    `TSLE_ASSERT_NXT(a_out_after_move, i_clk, i_rst_n, move, r_out_valid)

endmodule

// ===== rtl/text_stream_line_number_escape.sv =====
// An accepted item is held in the item buffer, and its bytes pass through the output register
// at one result byte per cycle while the output is not stalled. An item expands into 1 to 11
// bytes on the single output byte lane; the next item is taken as its last byte moves, so
// one-byte items run back to back. A squeezed blank line is accepted and yields nothing.
// Reset: synchronous, active low; clears configuration, line state and both buffers.
// ----------------------------------------------------------------------------
// text_stream_line_number_escape
// Text byte filter with line numbering, blank-line squeeze and visible escapes.
// ----------------------------------------------------------------------------
module text_stream_line_number_escape
    import tsle_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic                 i_cfg_data
);

    t_cfg r_cfg;
    logic accept;
    logic job_valid;
    logic job_ready;
    t_job job;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = !job_ready;
    assign accept      = i_in_valid && job_ready;

    // Configuration register writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_NUMBER_ALL:      r_cfg.number_all      <= i_cfg_data;
                REG_NUMBER_NONBLANK: r_cfg.number_nonblank <= i_cfg_data;
                REG_SQUEEZE_BLANK:   r_cfg.squeeze_blank   <= i_cfg_data;
                REG_SHOW_NONPRINT:   r_cfg.show_nonprint   <= i_cfg_data;
                REG_SHOW_TABS:       r_cfg.show_tabs       <= i_cfg_data;
                REG_SHOW_ENDS:       r_cfg.show_ends       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tsle_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_accept    (accept),
        .i_item      (i_in),
        .o_job_valid (job_valid),
        .o_job       (job)
    );

    tsle_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_job_ready (job_ready),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule
